/* rtl/pwn_pkg.sv */
package pwn_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 16;
   localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
   localparam int COUNT_BITS   = 9;
   localparam int WIND_BITS    = 9;
   localparam int OP_BITS      = 2;
   localparam int ENTRY_BITS   = 2 * COORD_BITS;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int CROSS_BITS   = PROD_BITS + 1;

   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_VERTICES);
   localparam logic [COUNT_BITS-1:0] COUNT_MIN_QUERY = COUNT_BITS'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_WALK,
      ST_CLOSE,
      ST_DRAIN
   } state_type;

endpackage

/* rtl/pwn_if.sv */
interface pwn_req_if
   import pwn_pkg::*;
   ();
   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           operation;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, operation, point_x, point_y, input ready);
   modport sink (input valid, operation, point_x, point_y, output ready);
endinterface

interface pwn_rsp_if
   import pwn_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic signed [WIND_BITS-1:0] winding;
   logic [COUNT_BITS-1:0]       vertex_count;
   logic                        full_flag;

   modport source (output valid, winding, vertex_count, full_flag, input ready);
   modport sink (input valid, winding, vertex_count, full_flag, output ready);
endinterface

/* rtl/pwn_ram.sv */
module pwn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/polygon_winding_number.sv */
// Winding number of a stored polygon around a query point.
//
// req_port carries one word per item: an operation and a point. An append
// stores the point as the next vertex, a clear empties the polygon and a
// query walks every edge of the closed polygon. rsp_port returns exactly one
// word per item: winding number (zero unless a query), vertex count after
// the item, and a flag for an append dropped on a full table.
// Append, clear and the spare code answer in the cycle after acceptance.
// A query over n >= 2 vertices is answered once the vertex memory has
// delivered one vertex per cycle through its single read port and the
// three stage cross product pipeline (edge, difference, product) has
// drained. Queries with fewer than two vertices answer at once. One item is
// in flight at a time.
// The result sits in an output register; req_port.ready stays high while it
// waits as long as it is being taken in the same cycle, otherwise the block
// holds off until rsp_port.ready. Synchronous reset empties the polygon,
// clears the output valid flag and returns to idle; vertex memory is not
// cleared.
module polygon_winding_number
   import pwn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pwn_req_if.sink    req_port,
   pwn_rsp_if.source  rsp_port
);

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   logic                         edge_valid_ff;
   logic signed [COORD_BITS-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   logic                        diff_valid_ff, diff_up_ff, diff_down_ff;
   logic signed [DIFF_BITS-1:0] da_ff, db_ff, dc_ff, dd_ff;

   logic                        prod_valid_ff, prod_up_ff, prod_down_ff;
   logic signed [PROD_BITS-1:0] pab_ff, pcd_ff;
   logic signed [CROSS_BITS-1:0] cross_sum;

   logic signed [WIND_BITS-1:0] wn_ff, wn_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [WIND_BITS-1:0] rsp_winding_ff, rsp_winding_in;
   logic [COUNT_BITS-1:0]       rsp_count_ff, rsp_count_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic req_fire, is_append, is_query, query_start, query_done, pipe_empty;
   logic has_room;
   logic ram_we, ram_re, edge_load;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [ENTRY_BITS-1:0] ram_rdata;
   logic signed [COORD_BITS-1:0] rd_x, rd_y;

   assign req_port.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_port.ready);
   assign req_fire    = req_port.valid && req_port.ready;
   assign is_append   = req_port.operation == OP_APPEND;
   assign is_query    = req_port.operation == OP_QUERY;
   assign has_room    = count_ff < COUNT_MAX;
   assign query_start = req_fire && is_query && (count_ff >= COUNT_MIN_QUERY);
   assign pipe_empty  = !edge_valid_ff && !diff_valid_ff && !prod_valid_ff;
   assign query_done  = (state_ff == ST_DRAIN) && pipe_empty;

   assign rd_x = ram_rdata[ENTRY_BITS-1:COORD_BITS];
   assign rd_y = ram_rdata[COORD_BITS-1:0];

   pwn_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[ADDR_BITS-1:0]),
      .wr_data ({req_port.point_x, req_port.point_y}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_start) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (idx_ff == count_ff) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memory and edge control
   always_comb begin
      ram_we    = req_fire && is_append && has_room;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[ADDR_BITS-1:0];
      edge_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_re    = query_start;
            ram_raddr = '0;
         end
         ST_FIRST: begin
            ram_re = 1'b1;
         end
         ST_WALK: begin
            ram_re    = idx_ff != count_ff;
            edge_load = 1'b1;
         end
         ST_CLOSE: begin
            edge_load = 1'b1;
         end
         ST_DRAIN: begin
            ram_re = 1'b0;
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire) begin
         case (req_port.operation)
            OP_APPEND: begin
               if (has_room) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (state_ff == ST_IDLE) begin
         idx_in = COUNT_BITS'(1);
      end else if (ram_re) begin
         idx_in = idx_ff + COUNT_BITS'(1);
      end
   end

   // cross product sign and accumulate
   assign cross_sum = CROSS_BITS'(pab_ff) - CROSS_BITS'(pcd_ff);

   always_comb begin
      wn_in = wn_ff;
      if (query_start) begin
         wn_in = '0;
      end else if (prod_valid_ff) begin
         if (prod_up_ff && (cross_sum > 0)) begin
            wn_in = wn_ff + WIND_BITS'(1);
         end else if (prod_down_ff && (cross_sum < 0)) begin
            wn_in = wn_ff - WIND_BITS'(1);
         end
      end
   end

   // response word
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_winding_in = rsp_winding_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_full_in    = rsp_full_ff;
      if (query_done) begin
         rsp_valid_in   = 1'b1;
         rsp_winding_in = wn_ff;
         rsp_count_in   = count_ff;
         rsp_full_in    = 1'b0;
      end else if (req_fire && !query_start) begin
         rsp_valid_in   = 1'b1;
         rsp_winding_in = '0;
         rsp_count_in   = count_in;
         rsp_full_in    = is_append && !has_room;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         wn_ff         <= '0;
         edge_valid_ff <= 1'b0;
         diff_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         wn_ff         <= wn_in;
         edge_valid_ff <= edge_load;
         diff_valid_ff <= edge_valid_ff;
         prod_valid_ff <= diff_valid_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (query_start) begin
         qx_ff <= req_port.point_x;
         qy_ff <= req_port.point_y;
      end
      if (state_ff == ST_FIRST) begin
         first_x_ff <= rd_x;
         first_y_ff <= rd_y;
         prev_x_ff  <= rd_x;
         prev_y_ff  <= rd_y;
      end else if (state_ff == ST_WALK) begin
         prev_x_ff <= rd_x;
         prev_y_ff <= rd_y;
      end
      if (edge_load) begin
         sx_ff <= prev_x_ff;
         sy_ff <= prev_y_ff;
         ex_ff <= (state_ff == ST_CLOSE) ? first_x_ff : rd_x;
         ey_ff <= (state_ff == ST_CLOSE) ? first_y_ff : rd_y;
      end
      diff_up_ff   <= (sy_ff <= qy_ff) && (qy_ff < ey_ff);
      diff_down_ff <= (sy_ff > qy_ff) && (ey_ff <= qy_ff);
      da_ff        <= DIFF_BITS'(ex_ff) - DIFF_BITS'(sx_ff);
      db_ff        <= DIFF_BITS'(qy_ff) - DIFF_BITS'(sy_ff);
      dc_ff        <= DIFF_BITS'(ey_ff) - DIFF_BITS'(sy_ff);
      dd_ff        <= DIFF_BITS'(qx_ff) - DIFF_BITS'(sx_ff);
      prod_up_ff   <= diff_up_ff;
      prod_down_ff <= diff_down_ff;
      pab_ff       <= PROD_BITS'(da_ff) * PROD_BITS'(db_ff);
      pcd_ff       <= PROD_BITS'(dc_ff) * PROD_BITS'(dd_ff);
      rsp_winding_ff <= rsp_winding_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_full_ff    <= rsp_full_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.winding      = rsp_winding_ff;
   assign rsp_port.vertex_count = rsp_count_ff;
   assign rsp_port.full_flag    = rsp_full_ff;

endmodule

/* rtl/pwn_checker.sv */
module pwn_checker
   import pwn_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [WIND_BITS-1:0] rsp_winding,
   input logic [COUNT_BITS-1:0]       rsp_vertex_count,
   input logic                        rsp_full_flag
);

   // stalled word is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_winding) && $stable(rsp_vertex_count)
         && $stable(rsp_full_flag))
      else $error("rsp word changed while stalled");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_vertex_count <= COUNT_BITS'(MAX_VERTICES))
      else $error("vertex count beyond table size");

   // a dropped append only happens on a full table and is no query
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_flag |->
         (rsp_vertex_count == COUNT_BITS'(MAX_VERTICES)) && (rsp_winding == '0))
      else $error("full flag with room left or with a winding");

endmodule

bind polygon_winding_number pwn_checker u_pwn_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_port.valid),
   .rsp_ready        (rsp_port.ready),
   .rsp_winding      (rsp_port.winding),
   .rsp_vertex_count (rsp_port.vertex_count),
   .rsp_full_flag    (rsp_port.full_flag)
);

/* verif/tb.sv */
module tb;
   import pwn_pkg::*;

   localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 1300;
   localparam int COUNT_TOP    = (1 << COUNT_BITS) - 1;

   typedef enum int {
      SPREAD_GRID,
      SPREAD_FULL,
      SPREAD_COARSE,
      SPREAD_EXTREME
   } spread_type;

   typedef struct packed {
      logic signed [WIND_BITS-1:0] winding;
      logic [COUNT_BITS-1:0]       vertex_count;
      logic                        full_flag;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pwn_req_if req_bus ();
   pwn_rsp_if rsp_bus ();

   polygon_winding_number i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   logic signed [COORD_BITS-1:0] corner_x [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] corner_y [MAX_VERTICES];
   int unsigned corner_count = 0;
   answer_type  answers_due [$];
   int unsigned error_count = 0;
   int unsigned sent_words  = 0;
   int unsigned cycle_count = 0;
   int unsigned long_hold   = 0;
   bit          idle_on     = 1'b1;

   always #4 clock = ~clock;

   function automatic answer_type polygon_step(input logic [OP_BITS-1:0] op,
                                               input logic signed [COORD_BITS-1:0] px,
                                               input logic signed [COORD_BITS-1:0] py);
      answer_type  ans;
      int          wn;
      int unsigned nxt;
      longint      sx, sy, ex, ey, cross_prod;
      ans = '0;
      wn  = 0;
      case (op)
         OP_APPEND: begin
            if (corner_count < MAX_VERTICES) begin
               corner_x[corner_count] = px;
               corner_y[corner_count] = py;
               corner_count++;
            end else begin
               ans.full_flag = 1'b1;
            end
         end
         OP_QUERY: begin
            for (int unsigned i = 0; i < corner_count; i++) begin
               nxt   = (i + 1 < corner_count) ? i + 1 : 0;
               sx    = corner_x[i];
               sy    = corner_y[i];
               ex    = corner_x[nxt];
               ey    = corner_y[nxt];
               cross_prod = (ex - sx) * (longint'(py) - sy)
                            - (ey - sy) * (longint'(px) - sx);
               if (sy <= py) begin
                  if (py < ey && cross_prod > 0) wn++;
               end else if (ey <= py && cross_prod < 0) begin
                  wn--;
               end
            end
            if (wn > 255) wn = 255;
            if (wn < -256) wn = -256;
            ans.winding = WIND_BITS'(wn);
         end
         OP_CLEAR: corner_count = 0;
         default: ;
      endcase
      ans.vertex_count = (corner_count > COUNT_TOP) ? COUNT_BITS'(COUNT_TOP)
                                                    : COUNT_BITS'(corner_count);
      return ans;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord(input spread_type spread);
      int v;
      case (spread)
         SPREAD_GRID:   v = int'($urandom_range(0, 16)) - 8;
         SPREAD_FULL:   v = $urandom;
         SPREAD_COARSE: v = (int'($urandom_range(0, 16)) - 8) * 4096;
         default: begin
            case ($urandom_range(0, 5))
               0:       v = -32768;
               1:       v = -32767;
               2:       v = -1;
               3:       v = 0;
               4:       v = 32766;
               default: v = 32767;
            endcase
         end
      endcase
      return COORD_BITS'(v);
   endfunction

   task automatic report_mismatch(input string what);
      if (error_count < 100) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic send_word(input logic [OP_BITS-1:0] op,
                            input logic signed [COORD_BITS-1:0] px,
                            input logic signed [COORD_BITS-1:0] py);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.point_x   <= px;
      req_bus.point_y   <= py;
      do @(posedge clock); while (!req_bus.ready);
      answers_due = {answers_due, polygon_step(op, px, py)};
      sent_words++;
   endtask

   task automatic probe_polygon(input spread_type spread);
      int unsigned pick, k, nxt;
      logic signed [COORD_BITS-1:0] qx, qy;
      pick = $urandom_range(0, 9);
      qx   = pick_coord(spread);
      qy   = pick_coord(spread);
      if (corner_count > 0) begin
         k   = $urandom_range(0, corner_count - 1);
         nxt = (k + 1 < corner_count) ? k + 1 : 0;
         if (pick < 3) begin
            qx = corner_x[k];
            qy = corner_y[k];
         end else if (pick < 5) begin
            qx = COORD_BITS'((longint'(corner_x[k]) + corner_x[nxt]) >>> 1);
            qy = COORD_BITS'((longint'(corner_y[k]) + corner_y[nxt]) >>> 1);
         end else if (pick == 5) begin
            qx = corner_x[k] + COORD_BITS'(int'($urandom_range(0, 2)) - 1);
            qy = corner_y[k] + COORD_BITS'(int'($urandom_range(0, 2)) - 1);
         end else if (pick == 6) begin
            qy = corner_y[k];
         end
      end
      send_word(OP_QUERY, qx, qy);
   endtask

   task automatic test_tiny_polygons();
      send_word(OP_QUERY, 0, 0);
      send_word(OP_SPARE, 32767, -1);
      send_word(OP_APPEND, -32768, -32768);
      send_word(OP_QUERY, -32768, -32768);
      send_word(OP_QUERY, 5, 5);
      send_word(OP_APPEND, 32767, 32767);
      send_word(OP_QUERY, 0, 0);
      send_word(OP_QUERY, 0, -32768);
   endtask

   task automatic test_square();
      send_word(OP_CLEAR, 0, 0);
      send_word(OP_APPEND, 0, 0);
      send_word(OP_APPEND, 10, 0);
      send_word(OP_APPEND, 10, 10);
      send_word(OP_APPEND, 0, 10);
      send_word(OP_QUERY, 5, 5);
      send_word(OP_QUERY, 0, 5);
      send_word(OP_QUERY, 10, 5);
      send_word(OP_QUERY, 5, 0);
      send_word(OP_QUERY, 5, 10);
      send_word(OP_QUERY, 10, 10);
   endtask

   task automatic test_extreme_corners();
      send_word(OP_CLEAR, -1, -1);
      send_word(OP_APPEND, -32768, -32768);
      send_word(OP_APPEND, -32768, 32767);
      send_word(OP_APPEND, 32767, -32768);
      send_word(OP_QUERY, -100, -100);
      send_word(OP_QUERY, 32767, 32767);
      send_word(OP_QUERY, -32768, 0);
   endtask

   task automatic test_full_table();
      send_word(OP_CLEAR, 0, 0);
      repeat (MAX_VERTICES)
         send_word(OP_APPEND, pick_coord(SPREAD_FULL), pick_coord(SPREAD_COARSE));
      repeat (2) send_word(OP_APPEND, pick_coord(SPREAD_EXTREME), pick_coord(SPREAD_EXTREME));
      repeat (3) probe_polygon(SPREAD_COARSE);
      send_word(OP_SPARE, 0, 0);
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      send_word(OP_CLEAR, 0, 0);
      long_hold = 200;
      repeat (12) send_word(OP_APPEND, pick_coord(SPREAD_GRID), pick_coord(SPREAD_GRID));
      repeat (3) probe_polygon(SPREAD_GRID);
      idle_on = 1'b1;
   endtask

   task automatic test_random_polygons();
      int unsigned start, kind, sides, laps, probes;
      spread_type spread;
      logic signed [COORD_BITS-1:0] lap_x [5];
      logic signed [COORD_BITS-1:0] lap_y [5];
      start = sent_words;
      while (sent_words - start < RANDOM_WORDS) begin
         idle_on = ($urandom_range(0, 5) != 0);
         kind    = $urandom_range(0, 9);
         spread  = spread_type'($urandom_range(0, 3));
         if (kind < 2) begin
            // noise, any code, onto whatever is stored
            repeat ($urandom_range(4, 16))
               send_word(OP_BITS'($urandom), pick_coord(spread), pick_coord(spread));
         end else begin
            if ($urandom_range(0, 7) != 0)
               send_word(OP_CLEAR, pick_coord(SPREAD_FULL), pick_coord(SPREAD_FULL));
            if (kind == 2) begin
               repeat ($urandom_range(0, 2))
                  send_word(OP_APPEND, pick_coord(spread), pick_coord(spread));
            end else if (kind == 3) begin
               // same loop walked several times over
               sides = $urandom_range(3, 5);
               laps  = $urandom_range(2, 4);
               for (int s = 0; s < sides; s++) begin
                  lap_x[s] = pick_coord(spread);
                  lap_y[s] = pick_coord(spread);
               end
               repeat (laps)
                  for (int s = 0; s < sides; s++) send_word(OP_APPEND, lap_x[s], lap_y[s]);
            end else begin
               sides = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 270)
                                                    : $urandom_range(3, 12);
               repeat (sides) begin
                  send_word(OP_APPEND, pick_coord(spread), pick_coord(spread));
                  if (corner_count < 64 && $urandom_range(0, 9) == 0) probe_polygon(spread);
               end
            end
            probes = (corner_count > 64) ? 2 : $urandom_range(2, 8);
            repeat (probes) probe_polygon(spread);
         end
      end
   endtask

   initial begin : rsp_side
      int unsigned hold;
      rsp_bus.ready = 1'b0;
      forever begin
         hold = idle_on ? $urandom_range(0, 3) : 0;
         if (long_hold > 0) begin
            hold      = long_hold;
            long_hold = 0;
         end
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("result word with nothing outstanding");
         end else begin
            due = answers_due.pop_front();
            if (rsp_bus.winding !== due.winding)
               report_mismatch($sformatf("winding %0d, wanted %0d",
                                         rsp_bus.winding, due.winding));
            if (rsp_bus.vertex_count !== due.vertex_count)
               report_mismatch($sformatf("vertex_count %0d, wanted %0d",
                                         rsp_bus.vertex_count, due.vertex_count));
            if (rsp_bus.full_flag !== due.full_flag)
               report_mismatch($sformatf("full_flag %0b, wanted %0b",
                                         rsp_bus.full_flag, due.full_flag));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_APPEND;
      req_bus.point_x   = '0;
      req_bus.point_y   = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_tiny_polygons();
      test_square();
      test_extreme_corners();
      test_full_table();
      test_backpressure();
      test_random_polygons();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (answers_due.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
